// File: rtl/pwmdc_pkg.sv
// Package for the PWM divider and duty calculator: widths, codes and the
// sideband record carried down the pipeline. No dependencies.
`timescale 1ns / 1ps
package pwmdc_pkg;

  localparam int unsigned MAX_PERIOD = 65536;
  localparam int unsigned DUTY_ONE   = 65536;
  localparam int unsigned DIV16_MIN  = 16;
  localparam int unsigned QBITS      = 12;   // 255*16+15 fits in 12 bits
  localparam int unsigned DEN_W      = 43;   // 26-bit frequency times 17-bit period
  localparam int unsigned NUM_W      = 43;   // clock*16 plus half the denominator
  localparam int unsigned CMP_W      = DEN_W + QBITS;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_INVALID = 2'd1;
  localparam logic [1:0] ST_RANGE   = 2'd2;

  localparam logic [1:0] DRV_PWM  = 2'd0;
  localparam logic [1:0] DRV_LOW  = 2'd1;
  localparam logic [1:0] DRV_HIGH = 2'd2;

  localparam logic [1:0] REG_SOURCE = 2'd0;
  localparam logic [1:0] REG_MAXF   = 2'd1;
  localparam logic [1:0] REG_PERIOD = 2'd2;

  typedef struct packed {
    logic [1:0]  status;
    logic [15:0] level;
    logic [1:0]  drive;
  } side_t;

endpackage

// File: rtl/pwmdc_divider.sv
// Restoring divider pipeline, one quotient bit per stage, with sideband.
// Depends on pwmdc_pkg.
`timescale 1ns / 1ps
module pwmdc_divider import pwmdc_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             en,
  input  logic             in_valid,
  input  logic [NUM_W-1:0] num,
  input  logic [DEN_W-1:0] den,
  input  side_t            in_side,
  output logic             out_valid,
  output logic [QBITS-1:0] quot,
  output side_t            out_side
);

  logic             valid [1:QBITS];
  logic [NUM_W-1:0] rem   [1:QBITS];
  logic [DEN_W-1:0] dv    [1:QBITS];
  logic [QBITS-1:0] q     [1:QBITS];
  side_t            sd    [1:QBITS];

  // Take one quotient bit per stage, highest first
  for (genvar i = 0; i < QBITS; i++) begin : g_stage
    localparam int unsigned B = QBITS - 1 - i;
    logic             v_i;
    logic [NUM_W-1:0] rem_i;
    logic [DEN_W-1:0] dv_i;
    logic [QBITS-1:0] q_i;
    side_t            sd_i;
    logic [CMP_W-1:0] shifted;
    logic             take;

    // Feed the first stage from the ports, the rest from the stage before
    if (i == 0) begin : g_first
      assign v_i   = in_valid;
      assign rem_i = num;
      assign dv_i  = den;
      assign q_i   = '0;
      assign sd_i  = in_side;
    end else begin : g_next
      assign v_i   = valid[i];
      assign rem_i = rem[i];
      assign dv_i  = dv[i];
      assign q_i   = q[i];
      assign sd_i  = sd[i];
    end

    assign shifted = {{QBITS{1'b0}}, dv_i} << B;
    assign take    = {{(CMP_W-NUM_W){1'b0}}, rem_i} >= shifted;

    always_ff @(posedge clk) begin
      if (rst) begin
        valid[i+1] <= 1'b0;
      end else if (en) begin
        valid[i+1] <= v_i;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem[i+1] <= take ? rem_i - shifted[NUM_W-1:0] : rem_i;
        q[i+1]   <= q_i | (QBITS'(take) << B);
        dv[i+1]  <= dv_i;
        sd[i+1]  <= sd_i;
      end
    end
  end

  assign out_valid = valid[QBITS];
  assign quot      = q[QBITS];
  assign out_side  = sd[QBITS];

endmodule

// File: rtl/pwm_divider_and_duty_calc.sv
// Top level: PWM clock divider and duty compare level calculator.
// Depends on pwmdc_pkg and pwmdc_divider.
//
//  channel | signals                         | carries
//  s_axis  | tvalid tready tdata[47:0]       | request_frequency, duty_fraction
//  m_axis  | tvalid tready tdata[31:0]       | status, divider, level, override
//  apb     | psel penable pwrite paddr[3:0]  | source clock, max frequency, period
//
// One item per cycle while the output is not stalled; 2 setup stages and
// 12 divider stages, one quotient bit each. Reset clears all valid bits, registers take
// their reset values. A stalled output freezes the whole pipeline; nothing
// is lost or repeated.
`timescale 1ns / 1ps
module pwm_divider_and_duty_calc import pwmdc_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [47:0] s_tdata,   // [25:0] request_frequency, [42:26] duty_fraction
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata,   // [1:0] status, [9:2] div_int,
                                 // [13:10] div_frac, [29:14] compare_level,
                                 // [31:30] drive_override
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic [29:0] source_clock_hz;
  logic [25:0] max_freq;
  logic [16:0] counter_period;
  logic        en;

  // Configuration registers
  assign pready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      source_clock_hz <= 30'd150000000;
      max_freq        <= 26'd1000000;
      counter_period  <= 17'd150;
    end else if (psel && penable && pwrite && pready) begin
      case (paddr[3:2])
        REG_SOURCE: source_clock_hz <= pwdata[29:0];
        REG_MAXF:   max_freq        <= pwdata[25:0];
        REG_PERIOD: counter_period  <= pwdata[16:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      REG_SOURCE: prdata = {2'b0, source_clock_hz};
      REG_MAXF:   prdata = {6'b0, max_freq};
      REG_PERIOD: prdata = {15'b0, counter_period};
      default:    prdata = '0;
    endcase
  end

  // Advance the whole pipeline unless the output item is held
  assign en       = !m_tvalid || m_tready;
  assign s_tready = en;

  // Stage 1: checks, saturation and both products
  logic [25:0] freq_in;
  logic [16:0] duty_in, duty_sat, per_sat;
  logic        bad_in;
  assign freq_in  = s_tdata[25:0];
  assign duty_in  = s_tdata[42:26];
  assign duty_sat = (duty_in > 17'(DUTY_ONE)) ? 17'(DUTY_ONE) : duty_in;
  assign per_sat  = (counter_period < 17'd2) ? 17'd2 :
                    (counter_period > 17'(MAX_PERIOD)) ? 17'(MAX_PERIOD) : counter_period;
  assign bad_in   = (freq_in == 26'd0) || (freq_in > max_freq) ||
                    (counter_period < 17'd2) || (counter_period > 17'(MAX_PERIOD));

  logic             v1, bad1;
  logic [DEN_W-1:0] den1;
  logic [33:0]      prod1;
  logic [16:0]      per1;
  logic [1:0]       drv1;
  logic [29:0]      src1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (en) begin
      v1 <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      bad1  <= bad_in;
      den1  <= DEN_W'(freq_in) * DEN_W'(counter_period);
      prod1 <= 34'(per_sat) * 34'(duty_sat);
      per1  <= per_sat;
      src1  <= source_clock_hz;
      drv1  <= (duty_sat == 17'd0) ? DRV_LOW :
               (duty_sat == 17'(DUTY_ONE)) ? DRV_HIGH : DRV_PWM;
    end
  end

  // Stage 2: numerator, range check and compare level
  logic [NUM_W-1:0] num_c;
  logic [17:0]      lvl_raw;
  logic [16:0]      lvl_c;
  logic             ovf_c;
  assign num_c   = NUM_W'({src1, 4'b0}) + (den1 >> 1);
  assign ovf_c   = {{QBITS{1'b0}}, num_c} >= {den1, {QBITS{1'b0}}};
  assign lvl_raw = 18'((prod1 + 34'd32768) >> 16);
  always_comb begin
    if (lvl_raw == 18'd0) begin
      lvl_c = 17'd1;
    end else if (lvl_raw >= {1'b0, per1}) begin
      lvl_c = per1 - 17'd1;
    end else begin
      lvl_c = lvl_raw[16:0];
    end
  end

  logic             v2;
  logic [NUM_W-1:0] num2;
  logic [DEN_W-1:0] den2;
  side_t            side2;

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (en) begin
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      num2         <= num_c;
      den2         <= den1;
      side2.status <= bad1 ? ST_INVALID : (ovf_c ? ST_RANGE : ST_OK);
      side2.drive  <= drv1;
      side2.level  <= (drv1 == DRV_PWM) ? lvl_c[15:0] : 16'd0;
    end
  end

  // Quotient bits
  logic             vq;
  logic [QBITS-1:0] quot;
  side_t            sq;

  pwmdc_divider u_div (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .in_valid (v2),
    .num      (num2),
    .den      (den2),
    .in_side  (side2),
    .out_valid(vq),
    .quot     (quot),
    .out_side (sq)
  );

  // Final status and packing
  logic [1:0]       st_out;
  logic [QBITS-1:0] div_out;
  assign st_out  = (sq.status == ST_OK && quot < QBITS'(DIV16_MIN)) ? ST_RANGE : sq.status;
  assign div_out = (st_out == ST_OK) ? quot : '0;

  assign m_tvalid = vq;
  assign m_tdata  = {sq.drive, sq.level, div_out[3:0], div_out[11:4], st_out};

  // Checks
  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[1:0] != ST_OK |-> m_tdata[13:2] == 12'd0)
    else $error("divider not cleared on error");
  a_ovr_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[31:30] != DRV_PWM |-> m_tdata[29:14] == 16'd0)
    else $error("level not cleared on override");
  a_lvl_min: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[31:30] == DRV_PWM |-> m_tdata[29:14] != 16'd0)
    else $error("compare level zero in normal mode");
  a_stall: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |-> !s_tready)
    else $error("input taken during output stall");

endmodule

// File: tb/sv/pwm_divider_and_duty_calc_tb.sv
// Testbench for the PWM divider and duty calculator: drives timing requests
// over the stream input, programs registers over APB, checks every result.
// Depends on pwmdc_pkg and the pwm_divider_and_duty_calc RTL.
`timescale 1ns / 1ps

class pwm_timing_board;
  logic [29:0] src_hz;
  logic [25:0] max_hz;
  logic [16:0] period;
  logic [31:0] pending[$];
  int errors;

  function new();
    src_hz = 30'd150000000;
    max_hz = 26'd1000000;
    period = 17'd150;
    errors = 0;
  endfunction

  // Compute the expected result word for one request
  function logic [31:0] calc_timing(logic [25:0] freq, logic [16:0] duty_in);
    logic [1:0] st;
    logic [1:0] drv;
    logic [63:0] den;
    logic [63:0] d16;
    logic [63:0] lvl;
    logic [16:0] per;
    logic [16:0] duty;
    st = pwmdc_pkg::ST_OK;
    d16 = 0;
    lvl = 0;
    drv = pwmdc_pkg::DRV_PWM;
    if (freq == 0 || freq > max_hz || period < 2 || period > 65536) begin
      st = pwmdc_pkg::ST_INVALID;
    end else begin
      den = 64'(freq) * 64'(period);
      d16 = (64'(src_hz) * 16 + den / 2) / den;
      if (d16 < 16 || d16 > 4095) begin
        st = pwmdc_pkg::ST_RANGE;
        d16 = 0;
      end
    end
    if (st != pwmdc_pkg::ST_OK) d16 = 0;
    duty = (duty_in > 17'd65536) ? 17'd65536 : duty_in;
    per = (period < 2) ? 17'd2 : (period > 65536) ? 17'd65536 : period;
    if (duty == 0) begin
      drv = pwmdc_pkg::DRV_LOW;
    end else if (duty == 17'd65536) begin
      drv = pwmdc_pkg::DRV_HIGH;
    end else begin
      lvl = (64'(per) * 64'(duty) + 32768) >> 16;
      if (lvl == 0) lvl = 1;
      if (lvl >= per) lvl = per - 1;
    end
    return {drv, lvl[15:0], d16[3:0], d16[11:4], st};
  endfunction

  function void note_request(logic [47:0] data);
    pending.push_back(calc_timing(data[25:0], data[42:26]));
  endfunction

  function void check_result(logic [31:0] got);
    logic [31:0] exp_w;
    if (pending.size() == 0) begin
      report("result with nothing pending", got, 0);
      return;
    end
    exp_w = pending.pop_front();
    if (got[1:0] != exp_w[1:0]) report("status", got[1:0], exp_w[1:0]);
    if (got[9:2] != exp_w[9:2]) report("div int", got[9:2], exp_w[9:2]);
    if (got[13:10] != exp_w[13:10]) report("div frac", got[13:10], exp_w[13:10]);
    if (got[29:14] != exp_w[29:14]) report("compare_level", got[29:14], exp_w[29:14]);
    if (got[31:30] != exp_w[31:30]) report("drive_override", got[31:30], exp_w[31:30]);
  endfunction

  function void report(string what, logic [31:0] got, logic [31:0] want);
    $display("MISMATCH %s: got %0d want %0d at %0t", what, got, want, $realtime);
    errors++;
  endfunction
endclass

module pwm_divider_and_duty_calc_tb import pwmdc_pkg::*;;

  logic clk = 0;
  logic rst = 1;
  logic s_tvalid = 0;
  logic s_tready;
  logic [47:0] s_tdata = 0;    // [25:0] request_frequency, [42:26] duty_fraction
  logic m_tvalid;
  logic m_tready = 0;
  logic [31:0] m_tdata;        // [1:0] status, [9:2] div int, [13:10] div frac,
                               // [29:14] compare_level, [31:30] drive_override
  logic psel = 0, penable = 0, pwrite = 0;
  logic [3:0] paddr = 0;
  logic [31:0] pwdata = 0;
  logic [31:0] prdata;
  logic pready;

  pwm_timing_board board;
  int cycles = 0;
  bit sink_calm = 0;
  bit source_calm = 0;
  int hold_off = 0;

  pwm_divider_and_duty_calc u_dut (.*);

  always begin
    #5 clk = 1;
    #5 clk = 0;
  end

  // Bound the run
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > 400000) begin
      $display("pwm_divider_and_duty_calc test failed");
      $finish;
    end
  end

  // Check results as they are accepted
  always @(posedge clk)
    if (!rst && m_tvalid && m_tready) board.check_result(m_tdata);

  // Receiver readiness: random stalls, calm stretches, a long hold-off
  always @(negedge clk) begin
    if (hold_off > 0) begin
      hold_off <= hold_off - 1;
      m_tready <= 0;
    end else begin
      m_tready <= sink_calm || ($urandom_range(99) >= 17);
    end
  end

  task automatic reg_write(logic [1:0] idx, logic [31:0] val);
    @(negedge clk);
    psel <= 1; penable <= 0; pwrite <= 1; paddr <= {idx, 2'b00}; pwdata <= val;
    @(negedge clk);
    penable <= 1;
    @(negedge clk);
    psel <= 0; penable <= 0; pwrite <= 0;
    case (idx)
      REG_SOURCE: board.src_hz = val[29:0];
      REG_MAXF:   board.max_hz = val[25:0];
      default:    board.period = val[16:0];
    endcase
  endtask

  // Offer one request and hold it until accepted
  task automatic send_request(logic [25:0] freq, logic [16:0] duty);
    while (!source_calm && $urandom_range(99) < 17) begin
      s_tvalid <= 0;
      @(negedge clk);
    end
    s_tvalid <= 1;
    s_tdata <= {5'd0, duty, freq};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    board.note_request({5'd0, duty, freq});
    @(negedge clk);
  endtask

  // Wait for the pipeline to drain before touching registers
  task automatic drain();
    s_tvalid <= 0;
    while (board.pending.size() != 0) @(negedge clk);
    repeat (20) @(negedge clk);
  endtask

  // Frequency that mostly lands in a legal divider for the current setting
  function automatic logic [25:0] pick_freq();
    int r;
    r = $urandom_range(99);
    if (r < 5) return 0;
    if (r < 12) return 26'($urandom);
    if (r < 20) return board.max_hz + 26'($urandom_range(3));
    if (r < 25) return board.max_hz;
    return 26'($urandom_range(board.max_hz > 0 ? board.max_hz : 1, 1));
  endfunction

  function automatic logic [16:0] pick_duty();
    int r;
    r = $urandom_range(99);
    if (r < 6) return 0;
    if (r < 12) return 17'd65536;
    if (r < 18) return 17'h1FFFF - 17'($urandom_range(100));
    if (r < 24) return 17'($urandom_range(3));
    return 17'($urandom);
  endfunction

  initial begin
    logic [31:0] src_set[6];
    logic [31:0] maxf_set[6];
    logic [31:0] per_set[6];
    int ph;
    src_set = '{32'd150000000, 32'd1000000000, 32'h3FFFFFFF,
                32'd0, 32'd1, 32'd48000000};
    maxf_set = '{32'd1000000, 32'd40000000, 32'h3FFFFFF,
                 32'd1, 32'd0, 32'd20000};
    per_set = '{32'd150, 32'd65536, 32'd2, 32'd1, 32'd0, 32'h1FFFF};
    board = new();
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 0;

    // Directed: extremes, each drive mode, each error class at reset settings, then an illegal period
    send_request(0, 0);
    send_request(26'd1000000, 17'd65536);
    send_request(26'd1000001, 17'd32768);
    send_request(26'h3FFFFFF, 17'h1FFFF);
    send_request(26'd1, 17'd1);
    send_request(26'd1000, 17'd65535);
    send_request(26'd3906, 17'd100);
    send_request(26'd3907, 17'd200);
    send_request(26'd62500, 17'd1000);
    send_request(26'd62499, 17'd65000);
    send_request(26'd1000000, 17'd65537);
    send_request(26'd50000, 17'h10000);
    drain();
    reg_write(REG_PERIOD, 32'd1);
    send_request(26'd1000, 17'd5);
    send_request(26'd1000, 17'd65535);
    drain();
    reg_write(REG_PERIOD, 32'd150);

    // Random phases over several register settings
    for (ph = 0; ph < 6; ph++) begin
      drain();
      reg_write(REG_SOURCE, src_set[ph]);
      reg_write(REG_MAXF, maxf_set[ph]);
      reg_write(REG_PERIOD, (ph == 5) ? 32'd1000 : per_set[ph]);
      sink_calm = (ph == 2);
      source_calm = (ph == 2);
      if (ph == 3) hold_off = 300;
      repeat (160) send_request(pick_freq(), pick_duty());
      if (ph == 1) begin
        drain();
        repeat (10) send_request(pick_freq(), pick_duty());
      end
    end
    sink_calm = 0;
    source_calm = 0;
    drain();
    repeat (10) @(negedge clk);
    if (board.errors == 0 && board.pending.size() == 0)
      $display("pwm_divider_and_duty_calc test passed");
    else
      $display("pwm_divider_and_duty_calc test failed");
    $finish;
  end
endmodule

// File: filelist.f
rtl/pwmdc_pkg.sv
rtl/pwmdc_divider.sv
rtl/pwm_divider_and_duty_calc.sv
tb/sv/pwm_divider_and_duty_calc_tb.sv
